>>> src/nsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Types, character codes and fixed-point constants of the NMEA decoder.
// ----------------------------------------------------------------------------
package nsd_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] CH_US     = 8'h53;
    localparam logic [7:0] CH_UW     = 8'h57;

    localparam logic [23:0] TYPE_GGA = 24'h474741;
    localparam logic [23:0] TYPE_RMC = 24'h524D43;

    // comma field numbers; some are shared by GGA and RMC
    localparam logic [4:0] FLD_STATUS  = 5'd2;
    localparam logic [4:0] FLD_LAT     = 5'd3;
    localparam logic [4:0] FLD_NS      = 5'd4;
    localparam logic [4:0] FLD_LON     = 5'd5;
    localparam logic [4:0] FLD_QUAL_EW = 5'd6;
    localparam logic [4:0] FLD_SATS_SP = 5'd7;
    localparam logic [4:0] FLD_HDOP_CR = 5'd8;
    localparam logic [4:0] FLD_ALT     = 5'd9;
    localparam logic [4:0] FLD_LAST    = 5'd31;

    localparam logic [3:0] SCAN_LEN = 4'd15;
    localparam logic [3:0] INT_LEN  = 4'd7;
    localparam logic [23:0] IPART_MAX = 24'd9999999;

    // reciprocals floor(2^k / C), k = width of the dividend
    localparam logic [17:0] RCP_100_K24   = 18'd167772;
    localparam logic [6:0]  RCP_1E4_K20   = 7'd104;
    localparam logic [12:0] RCP_1E5_K29   = 13'd5368;
    localparam logic [24:0] RCP_6_K27     = 25'd22369621;
    localparam logic [19:0] RCP_9_K23     = 20'd932067;
    localparam logic [21:0] RCP_100_K28   = 22'd2684354;

    localparam logic [29:0] LAT_MAX  = 30'd900000000;
    localparam logic [30:0] LON_MAX  = 31'd1800000000;
    localparam logic [18:0] SPD_MAX  = 19'd524287;
    localparam logic [13:0] HDOP_MAX = 14'd9999;
    localparam logic [15:0] CRS_MAX  = 16'd36000;
    localparam logic [19:0] ERR_MAX  = 20'd999900;
    localparam logic [24:0] ALT_MAX  = 25'd10000000;
    localparam logic [24:0] ALT_NEG  = 25'd100000;
    localparam logic [10:0] SPD_IPART_MAX = 11'd1100;

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_BODY  = 3'b010,
        PH_CHECK = 3'b100
    } phase_t;

    typedef enum logic [3:0] {
        FS_BLANK = 4'b0001,
        FS_INT   = 4'b0010,
        FS_FRAC  = 4'b0100,
        FS_STOP  = 4'b1000
    } fscan_t;

    typedef enum logic [2:0] {
        IS_BLANK = 3'b001,
        IS_DIGIT = 3'b010,
        IS_STOP  = 3'b100
    } iscan_t;

    typedef struct packed {
        logic       done;
        logic       clr;
        logic       fin;
        logic [4:0] fld;
        logic       set_stat;
        logic       set_lats;
        logic       set_lonw;
        logic       cmt_gga;
        logic       cmt_rmc;
        logic       fneg;
        logic       ineg;
    } ev_t;

    typedef struct packed {
        logic qual;
        logic sats;
        logic hdop;
        logic alt;
        logic lat;
        logic lon;
        logic spd;
        logic crs;
        logic stat;
        logic lats;
        logic lonw;
        logic latneg;
        logic lonneg;
    } pflag_t;

    function automatic logic [19:0] pow10_scale(input logic [2:0] digits);
        logic [19:0] r;
        unique case (digits)
            3'd0:    r = 20'd1000000;
            3'd1:    r = 20'd100000;
            3'd2:    r = 20'd10000;
            3'd3:    r = 20'd1000;
            3'd4:    r = 20'd100;
            3'd5:    r = 20'd10;
            default: r = 20'd1;
        endcase
        return r;
    endfunction

    // {ok, value}
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= CH_ZERO && b <= CH_NINE)
            r = {1'b1, 4'(b - CH_ZERO)};
        else if (b >= CH_UA && b <= CH_UF)
            r = {1'b1, 4'(b - CH_UA + 8'd10)};
        else if (b >= CH_LA && b <= CH_LF_HEX)
            r = {1'b1, 4'(b - CH_LA + 8'd10)};
        return r;
    endfunction

endpackage

>>> src/nmea_sentence_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_decoder
// NMEA GGA/RMC byte-stream parser with checksum check and fixed-point output.
// ----------------------------------------------------------------------------
// Each accepted byte passes the front parser, the arithmetic stages and the
// output register on its way to its result item. Throughput: one byte per cycle;
// the whole pipe advances whenever the output register is empty or taken.
// Reset: parser hunts for '$', measurement and update count read zero,
// range_error_factor is 500.
module nmea_sentence_decoder
    import nsd_pkg::*;
#(
    parameter int LINE_MAX = 128
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // data_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // sentence_done, fix_quality, satellites, fix_valid, hdop_centi,
    // error_estimate_cm, altitude_cm, latitude, longitude, speed_mm_s,
    // course_centi, update_count, zero fill
    output logic [191:0] m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [13:0]  cfg_data        // range_error_factor
);

    localparam int LEN_W = $clog2(LINE_MAX);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_MAX - 1);

    logic en, acc;
    logic [7:0] b;

    assign en  = !m_axis_tvalid || m_axis_tready;
    assign acc = s_axis_tvalid && en;
    assign b   = s_axis_tdata;
    assign s_axis_tready = en;
    assign cfg_ready = 1'b1;

    logic [13:0] ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_reg <= 14'd500;
        else if (cfg_valid)
            ref_reg <= cfg_data;
    end

    // ------------------------------------------------------------------ front
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       xor_reg, xor_next;
    logic [7:0]       rx_reg, rx_next;
    logic             hcnt_reg, hcnt_next;
    logic [4:0]       fld_reg, fld_next;
    logic [23:0]      type_reg, type_next;
    logic             end_reg, end_next;

    logic [3:0]  sc_pos_reg, sc_pos_next;
    fscan_t      sc_fph_reg, sc_fph_next;
    logic        sc_fneg_reg, sc_fneg_next;
    logic [23:0] sc_ipart_reg, sc_ipart_next;
    logic [19:0] sc_frac_reg, sc_frac_next;
    logic [2:0]  sc_fdig_reg, sc_fdig_next;
    iscan_t      sc_iph_reg, sc_iph_next;
    logic        sc_ineg_reg, sc_ineg_next;
    logic [7:0]  sc_ival_reg, sc_ival_next;

    ev_t         ev_next;
    logic        body_start, scan_clr, scan_step;
    logic        is_dig, is_blank, is_sign;
    logic [3:0]  dv;
    logic [26:0] ip_wide;
    logic [4:0]  hv;
    logic [7:0]  rx_new;
    logic        fin_ok;

    assign is_dig   = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_blank = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_VT) || (b == CH_FF);
    assign is_sign  = (b == CH_PLUS) || (b == CH_MINUS);
    assign dv       = 4'(b - CH_ZERO);
    assign ip_wide  = 27'(sc_ipart_reg) * 27'd10 + 27'(dv);
    assign hv       = hex_val(b);
    assign rx_new   = {rx_reg[3:0], hv[3:0]};
    assign fin_ok   = (sc_pos_reg != 4'd0);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        xor_next   = xor_reg;
        rx_next    = rx_reg;
        hcnt_next  = hcnt_reg;
        fld_next   = fld_reg;
        type_next  = type_reg;
        end_next   = end_reg;
        ev_next      = '0;
        ev_next.fld  = fld_reg;
        ev_next.fneg = sc_fneg_reg;
        ev_next.ineg = sc_ineg_reg;
        body_start = 1'b0;
        scan_clr   = 1'b0;
        scan_step  = 1'b0;

        unique case (phase_reg)
            PH_HUNT:
            begin
                if (b == CH_DOLLAR)
                begin
                    body_start = 1'b1;
                    phase_next = PH_BODY;
                end
            end
            PH_BODY:
            begin
                priority if (b == CH_DOLLAR)
                begin
                    body_start = 1'b1;
                end
                else if (b == CH_STAR)
                begin
                    ev_next.fin = !end_reg && fin_ok;
                    rx_next    = 8'd0;
                    hcnt_next  = 1'b0;
                    phase_next = PH_CHECK;
                end
                else if (b == CH_CR || b == CH_LF)
                begin
                    phase_next = PH_HUNT;
                end
                else
                begin
                    if (len_reg != LEN_LAST)
                    begin
                        if (len_reg >= LEN_W'(2) && len_reg <= LEN_W'(4))
                            type_next = {type_reg[15:0], b};
                        if (!end_reg)
                        begin
                            priority if (b == CH_NUL)
                            begin
                                ev_next.fin = fin_ok;
                                end_next    = 1'b1;
                            end
                            else if (b == CH_COMMA)
                            begin
                                ev_next.fin = fin_ok;
                                if (fld_reg != FLD_LAST)
                                    fld_next = fld_reg + 5'd1;
                                scan_clr = 1'b1;
                            end
                            else
                            begin
                                if (!fin_ok)
                                begin
                                    ev_next.set_stat = (fld_reg == FLD_STATUS) && (b == CH_UA);
                                    ev_next.set_lats = (fld_reg == FLD_NS) && (b == CH_US);
                                    ev_next.set_lonw = (fld_reg == FLD_QUAL_EW) && (b == CH_UW);
                                end
                                scan_step = 1'b1;
                            end
                        end
                        len_next = len_reg + LEN_W'(1);
                    end
                    xor_next = xor_reg ^ b;
                end
            end
            PH_CHECK:
            begin
                if (hv[4])
                begin
                    rx_next = rx_new;
                    if (hcnt_reg)
                    begin
                        if (rx_new == xor_reg)
                        begin
                            ev_next.done = 1'b1;
                            if (len_reg >= LEN_W'(6))
                            begin
                                ev_next.cmt_gga = (type_reg == TYPE_GGA);
                                ev_next.cmt_rmc = (type_reg == TYPE_RMC);
                            end
                        end
                        phase_next = PH_HUNT;
                    end
                    else
                    begin
                        hcnt_next = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_HUNT;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase

        if (body_start)
        begin
            ev_next.clr = 1'b1;
            len_next  = '0;
            xor_next  = 8'd0;
            fld_next  = 5'd0;
            type_next = 24'd0;
            end_next  = 1'b0;
            scan_clr  = 1'b1;
        end

        sc_pos_next   = sc_pos_reg;
        sc_fph_next   = sc_fph_reg;
        sc_fneg_next  = sc_fneg_reg;
        sc_ipart_next = sc_ipart_reg;
        sc_frac_next  = sc_frac_reg;
        sc_fdig_next  = sc_fdig_reg;
        sc_iph_next   = sc_iph_reg;
        sc_ineg_next  = sc_ineg_reg;
        sc_ival_next  = sc_ival_reg;

        if (scan_clr)
        begin
            sc_pos_next   = 4'd0;
            sc_fph_next   = FS_BLANK;
            sc_fneg_next  = 1'b0;
            sc_ipart_next = 24'd0;
            sc_frac_next  = 20'd0;
            sc_fdig_next  = 3'd0;
            sc_iph_next   = IS_BLANK;
            sc_ineg_next  = 1'b0;
            sc_ival_next  = 8'd0;
        end
        else if (scan_step)
        begin
            if (sc_pos_reg < SCAN_LEN)
            begin
                priority if (sc_fph_reg == FS_BLANK && is_blank)
                begin
                    sc_fph_next = FS_BLANK;
                end
                else if (sc_fph_reg == FS_BLANK && is_sign)
                begin
                    sc_fneg_next = (b == CH_MINUS);
                    sc_fph_next  = FS_INT;
                end
                else if ((sc_fph_reg == FS_BLANK || sc_fph_reg == FS_INT) && is_dig)
                begin
                    sc_ipart_next = (ip_wide > 27'(IPART_MAX)) ? IPART_MAX : ip_wide[23:0];
                    sc_fph_next   = FS_INT;
                end
                else if ((sc_fph_reg == FS_BLANK || sc_fph_reg == FS_INT) && b == CH_POINT)
                begin
                    sc_fph_next = FS_FRAC;
                end
                else if (sc_fph_reg == FS_FRAC && is_dig)
                begin
                    if (sc_fdig_reg < 3'd6)
                    begin
                        sc_frac_next = 20'(sc_frac_reg * 20'd10 + 20'(dv));
                        sc_fdig_next = sc_fdig_reg + 3'd1;
                    end
                end
                else
                begin
                    sc_fph_next = FS_STOP;
                end
                sc_pos_next = sc_pos_reg + 4'd1;
            end
            if (sc_pos_reg < INT_LEN)
            begin
                priority if (sc_iph_reg == IS_BLANK && is_blank)
                begin
                    sc_iph_next = IS_BLANK;
                end
                else if (sc_iph_reg == IS_BLANK && is_sign)
                begin
                    sc_ineg_next = (b == CH_MINUS);
                    sc_iph_next  = IS_DIGIT;
                end
                else if ((sc_iph_reg == IS_BLANK || sc_iph_reg == IS_DIGIT) && is_dig)
                begin
                    sc_ival_next = 8'(sc_ival_reg * 8'd10 + 8'(dv));
                    sc_iph_next  = IS_DIGIT;
                end
                else
                begin
                    sc_iph_next = IS_STOP;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            len_reg      <= '0;
            xor_reg      <= 8'd0;
            rx_reg       <= 8'd0;
            hcnt_reg     <= 1'b0;
            fld_reg      <= 5'd0;
            type_reg     <= 24'd0;
            end_reg      <= 1'b0;
            sc_pos_reg   <= 4'd0;
            sc_fph_reg   <= FS_BLANK;
            sc_fneg_reg  <= 1'b0;
            sc_ipart_reg <= 24'd0;
            sc_frac_reg  <= 20'd0;
            sc_fdig_reg  <= 3'd0;
            sc_iph_reg   <= IS_BLANK;
            sc_ineg_reg  <= 1'b0;
            sc_ival_reg  <= 8'd0;
        end
        else if (acc)
        begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            xor_reg      <= xor_next;
            rx_reg       <= rx_next;
            hcnt_reg     <= hcnt_next;
            fld_reg      <= fld_next;
            type_reg     <= type_next;
            end_reg      <= end_next;
            sc_pos_reg   <= sc_pos_next;
            sc_fph_reg   <= sc_fph_next;
            sc_fneg_reg  <= sc_fneg_next;
            sc_ipart_reg <= sc_ipart_next;
            sc_frac_reg  <= sc_frac_next;
            sc_fdig_reg  <= sc_fdig_next;
            sc_iph_reg   <= sc_iph_next;
            sc_ineg_reg  <= sc_ineg_next;
            sc_ival_reg  <= sc_ival_next;
        end
    end

    // ------------------------------------------------------- arithmetic pipe
    logic [9:1] vld_reg;
    ev_t ev1_reg, ev2_reg, ev3_reg, ev4_reg, ev5_reg, ev6_reg, ev7_reg, ev8_reg, ev9_reg;

    logic [23:0] ipart1_reg, ipart2_reg, ipart3_reg, ipart4_reg;
    logic [19:0] frac1_reg;
    logic [2:0]  fdig1_reg;
    logic [7:0]  ival1_reg;

    logic [19:0] frac6_2_reg, frac6_3_reg, frac6_4_reg;
    logic [3:0]  qual2_reg, qual3_reg, qual4_reg, qual5_reg, qual6_reg, qual7_reg,
                 qual8_reg, qual9_reg;
    logic [7:0]  sats2_reg, sats3_reg, sats4_reg, sats5_reg, sats6_reg, sats7_reg,
                 sats8_reg, sats9_reg;

    logic [41:0] d100p3_reg;
    logic [19:0] cx3_reg;
    logic [26:0] cp3_reg;
    logic [28:0] a3_reg, a4_reg;

    logic [17:0] deg4_reg;
    logic [6:0]  irem4_reg, cfrac4_reg;
    logic [41:0] ap4_reg;

    logic [29:0] centi5_reg;
    logic [26:0] mins5_reg;
    logic [12:0] aq5_reg;
    logic [30:0] degterm5_reg, degterm6_reg;
    logic        spd_big5_reg, spd_big6_reg;
    logic [10:0] ipc5_reg;

    logic [13:0] hdop6_reg, hdop7_reg, hdop8_reg, hdop9_reg;
    logic [15:0] crs6_reg, crs7_reg, crs8_reg, crs9_reg;
    logic [24:0] alt6_reg, alt7_reg, alt8_reg, alt9_reg;
    logic [26:0] m6x6_reg;
    logic [51:0] m6p6_reg;
    logic [22:0] y6_reg, y7_reg;

    logic [27:0] errm7_reg, errx8_reg, errx9_reg;
    logic [29:0] lat7_reg, lat8_reg, lat9_reg;
    logic [30:0] lon7_reg, lon8_reg, lon9_reg;
    logic [42:0] y9p7_reg;

    logic [49:0] errp8_reg, errp9_reg;
    logic [18:0] spd8_reg, spd9_reg;

    // stage 2
    logic [39:0] f6_prod;
    logic [3:0]  qual_c;
    logic [7:0]  sats_c;
    assign f6_prod = 40'(frac1_reg) * 40'(pow10_scale(fdig1_reg));
    assign qual_c  = ev1_reg.fneg ? 4'd0 :
                     (ipart1_reg > 24'd9) ? 4'd9 : ipart1_reg[3:0];
    assign sats_c  = ev1_reg.ineg ? 8'(8'd0 - ival1_reg) : ival1_reg;

    // stage 3
    logic [19:0] cx_c;
    assign cx_c = frac6_2_reg + 20'd5000;

    // stage 4: corrections of /100 and /10000, product for /100000
    logic [17:0] q100;
    logic [24:0] r100;
    logic [6:0]  cq;
    logic [20:0] cr;
    assign q100 = d100p3_reg[41:24];
    assign r100 = 25'(ipart3_reg) - 25'(q100) * 25'd100;
    assign cq   = cp3_reg[26:20];
    assign cr   = 21'(cx3_reg) - 21'(cq) * 21'd10000;

    // stage 5
    logic [12:0] aq;
    logic [29:0] ar;
    logic [7:0]  deg_c;
    assign aq    = ap4_reg[41:29];
    assign ar    = 30'(a4_reg) - 30'(aq) * 30'd100000;
    assign deg_c = (deg4_reg > 18'd181) ? 8'd181 : deg4_reg[7:0];

    // stage 7
    logic [24:0] q6;
    logic [27:0] r6;
    logic [24:0] q6c;
    logic [31:0] llsum;
    assign q6    = m6p6_reg[51:27];
    assign r6    = 28'(m6x6_reg) - 28'(q6) * 28'd6;
    assign q6c   = (r6 >= 28'd6) ? q6 + 25'd1 : q6;
    assign llsum = 32'(degterm6_reg) + 32'(q6c);

    // stage 8
    logic [19:0] q9;
    logic [23:0] r9;
    logic [19:0] q9c;
    assign q9  = y9p7_reg[42:23];
    assign r9  = 24'(y7_reg) - 24'(q9) * 24'd9;
    assign q9c = (r9 >= 24'd9) ? q9 + 20'd1 : q9;

    // stage 9 tail: error estimate /100 correction
    logic [21:0] eq;
    logic [28:0] er;
    logic [21:0] eqc;
    logic [19:0] err9;
    assign eq   = errp9_reg[49:28];
    assign er   = 29'(errx9_reg) - 29'(eq) * 29'd100;
    assign eqc  = (er >= 29'd100) ? eq + 22'd1 : eq;
    assign err9 = (eqc > 22'(ERR_MAX)) ? ERR_MAX : eqc[19:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[8:1], acc};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1
            ev1_reg    <= ev_next;
            ipart1_reg <= sc_ipart_reg;
            frac1_reg  <= sc_frac_reg;
            fdig1_reg  <= sc_fdig_reg;
            ival1_reg  <= sc_ival_reg;
            // stage 2
            ev2_reg     <= ev1_reg;
            ipart2_reg  <= ipart1_reg;
            frac6_2_reg <= f6_prod[19:0];
            qual2_reg   <= qual_c;
            sats2_reg   <= sats_c;
            // stage 3
            ev3_reg     <= ev2_reg;
            ipart3_reg  <= ipart2_reg;
            frac6_3_reg <= frac6_2_reg;
            qual3_reg   <= qual2_reg;
            sats3_reg   <= sats2_reg;
            d100p3_reg  <= 42'(ipart2_reg) * 42'(RCP_100_K24);
            cx3_reg     <= cx_c;
            cp3_reg     <= 27'(cx_c) * 27'(RCP_1E4_K20);
            a3_reg      <= 29'(frac6_2_reg) * 29'd463 + 29'd450000;
            // stage 4
            ev4_reg     <= ev3_reg;
            ipart4_reg  <= ipart3_reg;
            frac6_4_reg <= frac6_3_reg;
            qual4_reg   <= qual3_reg;
            sats4_reg   <= sats3_reg;
            if (r100 >= 25'd100)
            begin
                deg4_reg  <= q100 + 18'd1;
                irem4_reg <= 7'(r100 - 25'd100);
            end
            else
            begin
                deg4_reg  <= q100;
                irem4_reg <= r100[6:0];
            end
            cfrac4_reg <= (cr >= 21'd10000) ? cq + 7'd1 : cq;
            ap4_reg    <= 42'(a3_reg) * 42'(RCP_1E5_K29);
            a4_reg     <= a3_reg;
            // stage 5
            ev5_reg      <= ev4_reg;
            qual5_reg    <= qual4_reg;
            sats5_reg    <= sats4_reg;
            centi5_reg   <= 30'(ipart4_reg) * 30'd100 + 30'(cfrac4_reg);
            mins5_reg    <= 27'(irem4_reg) * 27'd1000000 + 27'(frac6_4_reg);
            aq5_reg      <= (ar >= 30'd100000) ? aq + 13'd1 : aq;
            degterm5_reg <= 31'(deg_c) * 31'd10000000;
            spd_big5_reg <= (ipart4_reg > 24'(SPD_IPART_MAX));
            ipc5_reg     <= ipart4_reg[10:0];
            // stage 6
            ev6_reg      <= ev5_reg;
            qual6_reg    <= qual5_reg;
            sats6_reg    <= sats5_reg;
            hdop6_reg    <= ev5_reg.fneg ? 14'd0 :
                            (centi5_reg > 30'(HDOP_MAX)) ? HDOP_MAX : centi5_reg[13:0];
            crs6_reg     <= ev5_reg.fneg ? 16'd0 :
                            (centi5_reg > 30'(CRS_MAX)) ? CRS_MAX : centi5_reg[15:0];
            if (ev5_reg.fneg)
                alt6_reg <= (centi5_reg > 30'(ALT_NEG)) ? 25'd0 - ALT_NEG
                                                       : 25'd0 - centi5_reg[24:0];
            else
                alt6_reg <= (centi5_reg > 30'(ALT_MAX)) ? ALT_MAX : centi5_reg[24:0];
            m6x6_reg     <= mins5_reg + 27'd3;
            m6p6_reg     <= 52'(mins5_reg + 27'd3) * 52'(RCP_6_K27);
            y6_reg       <= 23'(ipc5_reg) * 23'd4630 + 23'(aq5_reg);
            degterm6_reg <= degterm5_reg;
            spd_big6_reg <= spd_big5_reg;
            // stage 7
            ev7_reg   <= ev6_reg;
            qual7_reg <= qual6_reg;
            sats7_reg <= sats6_reg;
            hdop7_reg <= hdop6_reg;
            crs7_reg  <= crs6_reg;
            alt7_reg  <= alt6_reg;
            errm7_reg <= 28'(hdop6_reg) * 28'(ref_reg) + 28'd50;
            lat7_reg  <= (llsum > 32'(LAT_MAX)) ? LAT_MAX : llsum[29:0];
            lon7_reg  <= (llsum > 32'(LON_MAX)) ? LON_MAX : llsum[30:0];
            y9p7_reg  <= 43'(y6_reg) * 43'(RCP_9_K23);
            y7_reg    <= y6_reg;
            if (spd_big6_reg)
                y7_reg <= y6_reg;
            // stage 8
            ev8_reg   <= ev7_reg;
            qual8_reg <= qual7_reg;
            sats8_reg <= sats7_reg;
            hdop8_reg <= hdop7_reg;
            crs8_reg  <= crs7_reg;
            alt8_reg  <= alt7_reg;
            lat8_reg  <= lat7_reg;
            lon8_reg  <= lon7_reg;
            errp8_reg <= 50'(errm7_reg) * 50'(RCP_100_K28);
            errx8_reg <= errm7_reg;
            spd8_reg  <= ev7_reg.fneg ? 19'd0 :
                         (spd_big7 || q9c > 20'(SPD_MAX)) ? SPD_MAX : q9c[18:0];
            // stage 9
            ev9_reg   <= ev8_reg;
            qual9_reg <= qual8_reg;
            sats9_reg <= sats8_reg;
            hdop9_reg <= hdop8_reg;
            crs9_reg  <= crs8_reg;
            alt9_reg  <= alt8_reg;
            lat9_reg  <= lat8_reg;
            lon9_reg  <= lon8_reg;
            errp9_reg <= errp8_reg;
            errx9_reg <= errx8_reg;
            spd9_reg  <= spd8_reg;
        end
    end

    logic spd_big7;

    always_ff @(posedge clk)
    begin
        if (en)
            spd_big7 <= spd_big6_reg;
    end

    // ---------------------------------------------------- pending and commit
    pflag_t      pf_reg, pf_next;
    logic [3:0]  pq_reg, pq_next;
    logic [7:0]  ps_reg, ps_next;
    logic [13:0] ph_reg, ph_next;
    logic [19:0] pe_reg, pe_next;
    logic [24:0] pa_reg, pa_next;
    logic [29:0] plat_reg, plat_next;
    logic [30:0] plon_reg, plon_next;
    logic [18:0] pspd_reg, pspd_next;
    logic [15:0] pcrs_reg, pcrs_next;

    logic        done_reg;
    logic [3:0]  c_qual_reg, c_qual_next;
    logic [7:0]  c_sats_reg, c_sats_next;
    logic        c_valid_reg, c_valid_next;
    logic [13:0] c_hdop_reg, c_hdop_next;
    logic [19:0] c_err_reg, c_err_next;
    logic [24:0] c_alt_reg, c_alt_next;
    logic [30:0] c_lat_reg, c_lat_next;
    logic [31:0] c_lon_reg, c_lon_next;
    logic [18:0] c_spd_reg, c_spd_next;
    logic [15:0] c_crs_reg, c_crs_next;
    logic [15:0] c_upd_reg, c_upd_next;

    always_comb
    begin
        pf_next   = pf_reg;
        pq_next   = pq_reg;
        ps_next   = ps_reg;
        ph_next   = ph_reg;
        pe_next   = pe_reg;
        pa_next   = pa_reg;
        plat_next = plat_reg;
        plon_next = plon_reg;
        pspd_next = pspd_reg;
        pcrs_next = pcrs_reg;
        c_qual_next  = c_qual_reg;
        c_sats_next  = c_sats_reg;
        c_valid_next = c_valid_reg;
        c_hdop_next  = c_hdop_reg;
        c_err_next   = c_err_reg;
        c_alt_next   = c_alt_reg;
        c_lat_next   = c_lat_reg;
        c_lon_next   = c_lon_reg;
        c_spd_next   = c_spd_reg;
        c_crs_next   = c_crs_reg;
        c_upd_next   = c_upd_reg;

        if (ev9_reg.clr)
            pf_next = '0;
        if (ev9_reg.set_stat)
            pf_next.stat = 1'b1;
        if (ev9_reg.set_lats)
            pf_next.lats = 1'b1;
        if (ev9_reg.set_lonw)
            pf_next.lonw = 1'b1;

        if (ev9_reg.fin)
        begin
            case (ev9_reg.fld)
                FLD_LAT:
                begin
                    plat_next     = lat9_reg;
                    pf_next.lat   = 1'b1;
                    pf_next.latneg = pf_reg.latneg | ev9_reg.fneg;
                end
                FLD_LON:
                begin
                    plon_next     = lon9_reg;
                    pf_next.lon   = 1'b1;
                    pf_next.lonneg = pf_reg.lonneg | ev9_reg.fneg;
                end
                FLD_QUAL_EW:
                begin
                    pq_next      = qual9_reg;
                    pf_next.qual = 1'b1;
                end
                FLD_SATS_SP:
                begin
                    ps_next      = sats9_reg;
                    pspd_next    = spd9_reg;
                    pf_next.sats = 1'b1;
                    pf_next.spd  = 1'b1;
                end
                FLD_HDOP_CR:
                begin
                    ph_next      = hdop9_reg;
                    pe_next      = err9;
                    pcrs_next    = crs9_reg;
                    pf_next.hdop = 1'b1;
                    pf_next.crs  = 1'b1;
                end
                FLD_ALT:
                begin
                    pa_next     = alt9_reg;
                    pf_next.alt = 1'b1;
                end
                default:
                begin
                    pf_next = pf_next;
                end
            endcase
        end

        if (ev9_reg.cmt_gga)
        begin
            if (pf_reg.sats)
                c_sats_next = ps_reg;
            if (pf_reg.qual)
            begin
                c_qual_next  = pq_reg;
                c_valid_next = (pq_reg >= 4'd1) && (c_sats_next >= 8'd3);
            end
            if (pf_reg.hdop)
            begin
                c_hdop_next = ph_reg;
                c_err_next  = pe_reg;
            end
            if (pf_reg.alt)
                c_alt_next = pa_reg;
        end

        if (ev9_reg.cmt_rmc && pf_reg.stat)
        begin
            if (pf_reg.lat)
                c_lat_next = (pf_reg.latneg != pf_reg.lats) ? 31'd0 - {1'b0, plat_reg}
                                                            : {1'b0, plat_reg};
            if (pf_reg.lon)
                c_lon_next = (pf_reg.lonneg != pf_reg.lonw) ? 32'd0 - {1'b0, plon_reg}
                                                            : {1'b0, plon_reg};
            if (pf_reg.spd)
                c_spd_next = pspd_reg;
            if (pf_reg.crs)
                c_crs_next = pcrs_reg;
        end

        if (ev9_reg.cmt_gga || ev9_reg.cmt_rmc)
            c_upd_next = c_upd_reg + 16'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en && vld_reg[9])
        begin
            pq_reg   <= pq_next;
            ps_reg   <= ps_next;
            ph_reg   <= ph_next;
            pe_reg   <= pe_next;
            pa_reg   <= pa_next;
            plat_reg <= plat_next;
            plon_reg <= plon_next;
            pspd_reg <= pspd_next;
            pcrs_reg <= pcrs_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
            done_reg      <= 1'b0;
            pf_reg        <= '0;
            c_qual_reg    <= 4'd0;
            c_sats_reg    <= 8'd0;
            c_valid_reg   <= 1'b0;
            c_hdop_reg    <= 14'd0;
            c_err_reg     <= 20'd0;
            c_alt_reg     <= 25'd0;
            c_lat_reg     <= 31'd0;
            c_lon_reg     <= 32'd0;
            c_spd_reg     <= 19'd0;
            c_crs_reg     <= 16'd0;
            c_upd_reg     <= 16'd0;
        end
        else if (en)
        begin
            m_axis_tvalid <= vld_reg[9];
            if (vld_reg[9])
            begin
                done_reg    <= ev9_reg.done;
                pf_reg      <= pf_next;
                c_qual_reg  <= c_qual_next;
                c_sats_reg  <= c_sats_next;
                c_valid_reg <= c_valid_next;
                c_hdop_reg  <= c_hdop_next;
                c_err_reg   <= c_err_next;
                c_alt_reg   <= c_alt_next;
                c_lat_reg   <= c_lat_next;
                c_lon_reg   <= c_lon_next;
                c_spd_reg   <= c_spd_next;
                c_crs_reg   <= c_crs_next;
                c_upd_reg   <= c_upd_next;
            end
        end
    end

    assign m_axis_tdata = {5'd0, c_upd_reg, c_crs_reg, c_spd_reg, c_lon_reg, c_lat_reg,
                           c_alt_reg, c_err_reg, c_hdop_reg, c_valid_reg, c_sats_reg,
                           c_qual_reg, done_reg};

endmodule
